// File: design/rom_ram_bank_mapper_assert.svh
// Assertion macros used by the bank mapper top level.
`ifndef ROM_RAM_BANK_MAPPER_ASSERT_SVH
`define ROM_RAM_BANK_MAPPER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RRBM_ASSERT_IMP(name, clk_i, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk_i) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RRBM_ASSERT_NXT(name, clk_i, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk_i) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/rrbm_pkg.sv
// Types and constants shared by the bank mapper modules.
package rrbm_pkg;

	// Address pages of 8 KiB, selected by bus address bits 15:13.
	typedef enum logic [2:0] {
		PG_RAM_EN   = 3'd0,
		PG_ROM_BANK = 3'd1,
		PG_UPPER    = 3'd2,
		PG_MODE     = 3'd3,
		PG_VIDEO    = 3'd4,
		PG_SAVE     = 3'd5,
		PG_WORK     = 3'd6,
		PG_HIGH     = 3'd7
	} page_t;

	localparam logic [7:0] RAM_EN_KEY    = 8'h0A;
	localparam logic [7:0] BYTE_FF       = 8'hFF;
	localparam logic [4:0] ROM_BANK_ONE  = 5'd1;
	localparam int         BANK_OFS_BITS = 13;

	typedef struct packed {
		logic we;
		logic re;
	} ram_ctl_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        rom_fetch;
		logic [20:0] rom_address;
		logic        unsupported;
		logic        ram_read;
	} result_t;

endpackage

// File: design/rrbm_ctrl.sv
// Mapper registers and the access decoder for one bus beat.
module rrbm_ctrl import rrbm_pkg::*; #(
	parameter int RAM_BANKS = 4,
	parameter int AW        = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ram_present,
	input  logic          adv,
	input  logic          mode_s1,
	input  logic [15:0]   addr_s1,
	input  logic [7:0]    data_s1,
	output result_t       res,
	output ram_ctl_t      ram_ctl,
	output logic [AW-1:0] ram_index
);

	localparam logic [2:0] NUM_BANKS = 3'(RAM_BANKS);

	logic       ram_enabled_q;
	logic [4:0] low_rom_bank_q;
	logic [1:0] upper_bank_q;
	logic       bank_mode_q;

	page_t      page;
	logic       ram_ok;
	logic [6:0] rom_bank;
	logic [2:0] wrap0, wrap1, wrap2, wrap3;

	assign page     = page_t'(addr_s1[15:13]);
	assign ram_ok   = (page == PG_SAVE) && ram_enabled_q && ram_present;
	assign rom_bank = bank_mode_q ? {upper_bank_q, low_rom_bank_q} : {2'b00, low_rom_bank_q};

	// The RAM bank wraps modulo the bank count; three compare-subtract steps cover
	// every count from one to four on a two-bit bank number.
	assign wrap0 = bank_mode_q ? 3'd0 : {1'b0, upper_bank_q};
	assign wrap1 = (wrap0 >= NUM_BANKS) ? wrap0 - NUM_BANKS : wrap0;
	assign wrap2 = (wrap1 >= NUM_BANKS) ? wrap1 - NUM_BANKS : wrap1;
	assign wrap3 = (wrap2 >= NUM_BANKS) ? wrap2 - NUM_BANKS : wrap2;

	assign ram_index = AW'({wrap3[1:0], addr_s1[BANK_OFS_BITS-1:0]});

	always_comb begin
		res     = '0;
		ram_ctl = '0;
		if (mode_s1) begin
			unique case (page) inside
				PG_RAM_EN, PG_ROM_BANK, PG_UPPER, PG_MODE: begin
				end
				PG_SAVE: begin
					if (ram_ok) begin
						ram_ctl.we = adv;
					end else begin
						res.unsupported = 1'b1;
					end
				end
				default: begin
					res.unsupported = 1'b1;
				end
			endcase
		end else begin
			unique case (page) inside
				PG_RAM_EN, PG_ROM_BANK: begin
					res.rom_fetch   = 1'b1;
					res.rom_address = {7'd0, addr_s1[13:0]};
				end
				PG_UPPER, PG_MODE: begin
					res.rom_fetch   = 1'b1;
					res.rom_address = {rom_bank, addr_s1[13:0]};
				end
				PG_SAVE: begin
					if (ram_ok) begin
						res.ram_read = 1'b1;
						ram_ctl.re   = adv;
					end else begin
						res.unsupported = 1'b1;
						res.read_data   = BYTE_FF;
					end
				end
				default: begin
					res.unsupported = 1'b1;
					res.read_data   = BYTE_FF;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_enabled_q  <= 1'b0;
			low_rom_bank_q <= ROM_BANK_ONE;
			upper_bank_q   <= 2'd0;
			bank_mode_q    <= 1'b0;
		end else if (adv && mode_s1) begin
			unique case (page)
				PG_RAM_EN:   ram_enabled_q  <= (data_s1 & RAM_EN_KEY) == RAM_EN_KEY;
				PG_ROM_BANK: low_rom_bank_q <= (data_s1 == 8'd0) ? ROM_BANK_ONE : data_s1[4:0];
				PG_UPPER:    upper_bank_q   <= data_s1[1:0];
				PG_MODE:     bank_mode_q    <= data_s1[0];
				default: begin
				end
			endcase
		end
	end

endmodule

// File: design/rrbm_ram.sv
// Banked save RAM with a registered read port and a clearing pass after reset.
module rrbm_ram import rrbm_pkg::*; #(
	parameter int RAM_BANKS = 4,
	parameter int AW        = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ram_ctl_t      ram_ctl,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata,
	output logic          clearing
);

	localparam int            DEPTH = RAM_BANKS * (1 << BANK_OFS_BITS);
	localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rdata_q;
	logic [AW-1:0] clr_addr_q;
	logic          clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == LAST) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// No beat reaches the RAM while the clearing pass runs.
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (ram_ctl.we) begin
			mem[addr] <= wdata;
		end
		if (ram_ctl.re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata    = rdata_q;
	assign clearing = clearing_q;

endmodule

// File: design/rom_ram_bank_mapper.sv
// Top level of the cartridge ROM/RAM bank mapper.
// Usage:
//   Request channel (req_valid / req_stall): one bus access per beat, with mode
//   (0 read, 1 write), bus_address and write_data. The mapper drives req_stall.
//   Response channel (rsp_valid / rsp_stall): exactly one result beat per
//   request, in order: read_data, rom_fetch, rom_address, unsupported.
//   Configuration channel (cfg_valid / cfg_ready): writes ram_present; it is
//   always ready and should only be written while no request is in flight.
// A request beat passes an input register, then the decode and the single save
// RAM access into the result register and the RAM read register.
// Throughput is one beat per cycle while the receiver does not stall, set by the
// one RAM port that each beat uses. After reset the save RAM is cleared one byte
// a cycle, and req_stall stays high until the pass is done. Mapper registers
// reset to RAM disabled, ROM bank 1, upper bank 0, simple banking mode.
// When the receiver stalls, the result holds and the input register still takes
// one more beat; further requests stall until the result beat is taken.
`include "rom_ram_bank_mapper_assert.svh"

module rom_ram_bank_mapper import rrbm_pkg::*; #(
	parameter int RAM_BANKS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        mode,
	input  logic [15:0] bus_address,
	input  logic [7:0]  write_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [7:0]  read_data,
	output logic        rom_fetch,
	output logic [20:0] rom_address,
	output logic        unsupported,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        ram_present
);

	localparam int AW = $clog2(RAM_BANKS * (1 << BANK_OFS_BITS));

	logic          ram_present_q;
	logic          valid_s1;
	logic          mode_s1;
	logic [15:0]   addr_s1;
	logic [7:0]    data_s1;
	logic          valid_s2;
	logic [7:0]    rd_s2;
	logic          fetch_s2;
	logic [20:0]   raddr_s2;
	logic          bad_s2;
	logic          ram_read_s2;

	logic          s2_free;
	logic          adv;
	logic          accept;
	logic          clearing;
	result_t       res;
	ram_ctl_t      ram_ctl;
	logic [AW-1:0] ram_index;
	logic [7:0]    ram_rdata;

	assign cfg_ready = 1'b1;
	assign s2_free   = !valid_s2 || !rsp_stall;
	assign adv       = valid_s1 && s2_free;
	assign req_stall = clearing || (valid_s1 && !s2_free);
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_present_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			ram_present_q <= ram_present;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!rsp_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			addr_s1 <= bus_address;
			data_s1 <= write_data;
		end
		if (adv) begin
			rd_s2       <= res.read_data;
			fetch_s2    <= res.rom_fetch;
			raddr_s2    <= res.rom_address;
			bad_s2      <= res.unsupported;
			ram_read_s2 <= res.ram_read;
		end
	end

	rrbm_ctrl #(
		.RAM_BANKS (RAM_BANKS),
		.AW        (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.ram_present (ram_present_q),
		.adv         (adv),
		.mode_s1     (mode_s1),
		.addr_s1     (addr_s1),
		.data_s1     (data_s1),
		.res         (res),
		.ram_ctl     (ram_ctl),
		.ram_index   (ram_index)
	);

	rrbm_ram #(
		.RAM_BANKS (RAM_BANKS),
		.AW        (AW)
	) u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.ram_ctl  (ram_ctl),
		.addr     (ram_index),
		.wdata    (data_s1),
		.rdata    (ram_rdata),
		.clearing (clearing)
	);

	assign rsp_valid   = valid_s2;
	assign read_data   = ram_read_s2 ? ram_rdata : rd_s2;
	assign rom_fetch   = fetch_s2;
	assign rom_address = raddr_s2;
	assign unsupported = bad_s2;

	`RRBM_ASSERT_NXT(a_adv_gives_rsp, clk, arst_n, adv, rsp_valid,
		"an advancing beat did not produce a response")
	`RRBM_ASSERT_IMP(a_fetch_not_bad, clk, arst_n, rsp_valid, !(rom_fetch && unsupported),
		"a response is both a ROM fetch and unsupported")
	`RRBM_ASSERT_IMP(a_fetch_zero_data, clk, arst_n, rsp_valid && rom_fetch, read_data == 8'd0,
		"a ROM fetch response carries nonzero read data")
	`RRBM_ASSERT_IMP(a_no_ram_in_clear, clk, arst_n, clearing, !ram_ctl.we && !ram_ctl.re && !valid_s1,
		"a beat reached the save RAM during the clearing pass")

endmodule
